FILE: src/arpc_pkg.sv
// Shared types, codes and defaults of the ARP cache and responder.
`default_nettype none

package arpc_pkg;

    // Default neighbor table depth
    localparam int DEF_ENTRIES = 16;

    // Configuration write port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_HW_TYPE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_PROTO_TYPE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_HW_LEN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_PROTO_LEN   = 3'd5;

    // Register reset values
    localparam logic [15:0] RST_HW_TYPE    = 16'h0001;
    localparam logic [15:0] RST_PROTO_TYPE = 16'h0800;
    localparam logic [7:0]  RST_HW_LEN     = 8'd6;
    localparam logic [7:0]  RST_PROTO_LEN  = 8'd4;

    // ARP operation codes
    localparam logic [1:0] OP_REQUEST = 2'd1;
    localparam logic [1:0] OP_REPLY   = 2'd2;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_MSG     = 2'd0,
        KIND_LOOKUP  = 2'd1,
        KIND_REQUEST = 2'd2
    } t_kind;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SEARCH = 2'd1,
        S_FINISH = 2'd2
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] msg_operation;
        logic [15:0] msg_hw_type;
        logic [15:0] msg_proto_type;
        logic [7:0]  msg_hw_len;
        logic [7:0]  msg_proto_len;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [47:0] target_mac;
        logic [31:0] target_ip;
    } t_in_item;

    typedef struct packed {
        logic        emit;
        logic [1:0]  out_operation;
        logic [47:0] out_sender_mac;
        logic [31:0] out_sender_ip;
        logic [47:0] out_target_mac;
        logic [31:0] out_target_ip;
        logic [47:0] lookup_mac;
        logic        lookup_hit;
        logic        message_valid;
        logic        learned;
        logic        table_full;
    } t_out_item;

    // Search token handed from cell to cell
    typedef struct packed {
        logic        vld;
        logic [31:0] key;
        logic        hit;
        logic [47:0] mac;
    } t_token;

    // Entry write broadcast to all cells (index travels beside it)
    typedef struct packed {
        logic        en;
        logic [31:0] ip;
        logic [47:0] mac;
    } t_entry_wr;

endpackage

`default_nettype wire

FILE: src/arpc_if.sv
// Valid/ready channel interfaces for items, results and configuration writes.
`default_nettype none

interface arpc_req_if;
    logic                valid;
    logic                ready;
    arpc_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface arpc_rsp_if;
    logic                valid;
    logic                ready;
    arpc_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface arpc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [arpc_pkg::CFG_IDX_W-1:0]   index;
    logic [arpc_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/arpc_cell.sv
// One neighbor table cell: holds an entry and advances the search token.
`default_nettype none

module arpc_cell #(
    parameter int ENTRIES  = arpc_pkg::DEF_ENTRIES,
    parameter int CELL_IDX = 0
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  arpc_pkg::t_token             i_tok,
    input  arpc_pkg::t_entry_wr          i_wr,
    input  wire [$clog2(ENTRIES)-1:0]    i_wr_idx,
    output arpc_pkg::t_token             o_tok
);
    localparam int IDX_W = $clog2(ENTRIES);

    logic        r_valid;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    arpc_pkg::t_token r_tok;

    logic w_sel;
    logic w_match;

    assign w_sel   = i_wr.en && (i_wr_idx == IDX_W'(CELL_IDX));
    assign w_match = r_valid && (r_ip == i_tok.key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_sel) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            r_ip  <= i_wr.ip;
            r_mac <= i_wr.mac;
        end
    end

    // Advance token; the earliest match keeps its MAC
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= i_tok.vld;
        end
        r_tok.key <= i_tok.key;
        r_tok.hit <= i_tok.hit | w_match;
        r_tok.mac <= i_tok.hit ? i_tok.mac : (w_match ? r_mac : 48'd0);
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

FILE: src/arp_cache_responder.sv
// Top level of the ARP cache and responder: control, checks, output register.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+----------------------------------------
//  i_cfg    | in  | valid / ready   | register index (3b), write data (48b)
//  i_req    | in  | valid / ready   | kind, ARP header fields, addresses
//  o_rsp    | out | valid / ready   | outgoing message, lookup, learn status
//
// One item is handled at a time: the search token walks the row of ENTRIES
// cells, through the register of each cell in turn, then the result is
// captured and loaded into the output register before the next is taken.
// A finished result waits in the output register; the next item is taken
// while it waits, and only the load of the following result stalls on it.
// Reset (synchronous, active low) clears the cell valid bits, fill count,
// configuration registers to their defaults and all handshake state.
// The configuration port is always ready.
`default_nettype none

module arp_cache_responder #(
    parameter int ENTRIES = arpc_pkg::DEF_ENTRIES
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    arpc_cfg_if.sink      i_cfg,
    arpc_req_if.sink      i_req,
    arpc_rsp_if.source    o_rsp
);
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int FILL_W = $clog2(ENTRIES + 1);

    // Configuration registers
    logic [31:0] r_own_ip;
    logic [47:0] r_own_mac;
    logic [15:0] r_exp_hw_type;
    logic [15:0] r_exp_proto_type;
    logic [7:0]  r_exp_hw_len;
    logic [7:0]  r_exp_proto_len;

    // Control
    arpc_pkg::t_state r_state, n_state;
    arpc_pkg::t_in_item r_item;
    logic              r_hit;
    logic [47:0]       r_mac;
    logic [FILL_W-1:0] r_fill;
    logic              r_out_valid;
    arpc_pkg::t_out_item r_out;

    logic w_accept;
    logic w_capture;
    logic w_finish;
    logic w_out_free;

    // Cell row
    arpc_pkg::t_token    w_tok [ENTRIES+1];
    arpc_pkg::t_entry_wr w_wr;

    // Result logic
    logic w_msg_ok;
    logic w_known;
    logic w_is_msg;
    logic w_full;
    logic w_learn;
    logic w_drop;
    logic w_reply;
    arpc_pkg::t_out_item w_res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip         <= 32'd0;
            r_own_mac        <= 48'd0;
            r_exp_hw_type    <= arpc_pkg::RST_HW_TYPE;
            r_exp_proto_type <= arpc_pkg::RST_PROTO_TYPE;
            r_exp_hw_len     <= arpc_pkg::RST_HW_LEN;
            r_exp_proto_len  <= arpc_pkg::RST_PROTO_LEN;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                arpc_pkg::CFG_OWN_IP:         r_own_ip         <= i_cfg.data[31:0];
                arpc_pkg::CFG_OWN_MAC:        r_own_mac        <= i_cfg.data;
                arpc_pkg::CFG_EXP_HW_TYPE:    r_exp_hw_type    <= i_cfg.data[15:0];
                arpc_pkg::CFG_EXP_PROTO_TYPE: r_exp_proto_type <= i_cfg.data[15:0];
                arpc_pkg::CFG_EXP_HW_LEN:     r_exp_hw_len     <= i_cfg.data[7:0];
                arpc_pkg::CFG_EXP_PROTO_LEN:  r_exp_proto_len  <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            arpc_pkg::S_IDLE: begin
                if (i_req.valid) n_state = arpc_pkg::S_SEARCH;
            end
            arpc_pkg::S_SEARCH: begin
                if (w_tok[ENTRIES].vld) n_state = arpc_pkg::S_FINISH;
            end
            arpc_pkg::S_FINISH: begin
                if (w_out_free) n_state = arpc_pkg::S_IDLE;
            end
            default: n_state = arpc_pkg::S_IDLE;
        endcase
    end

    // State outputs
    assign w_out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        i_req.ready = 1'b0;
        w_capture   = 1'b0;
        w_finish    = 1'b0;
        case (r_state)
            arpc_pkg::S_IDLE:   i_req.ready = 1'b1;
            arpc_pkg::S_SEARCH: w_capture   = w_tok[ENTRIES].vld;
            arpc_pkg::S_FINISH: w_finish    = w_out_free;
            default: begin
            end
        endcase
    end

    assign w_accept = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arpc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the item for the whole search
    always_ff @(posedge i_clk) begin
        if (w_accept) r_item <= i_req.data;
        if (w_capture) begin
            r_hit <= w_tok[ENTRIES].hit;
            r_mac <= w_tok[ENTRIES].mac;
        end
    end

    // Launch token: lookups search on target IP, messages and requests on sender IP
    always_comb begin
        w_tok[0].vld = w_accept;
        w_tok[0].key = (i_req.data.kind == arpc_pkg::KIND_LOOKUP) ?
                       i_req.data.target_ip : i_req.data.sender_ip;
        w_tok[0].hit = 1'b0;
        w_tok[0].mac = 48'd0;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        arpc_cell #(
            .ENTRIES  (ENTRIES),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok    (w_tok[g]),
            .i_wr     (w_wr),
            .i_wr_idx (r_fill[IDX_W-1:0]),
            .o_tok    (w_tok[g+1])
        );
    end

    // Message checks and learn decision
    assign w_is_msg = (r_item.kind == arpc_pkg::KIND_MSG);
    assign w_msg_ok = ((r_item.msg_operation == 16'(arpc_pkg::OP_REQUEST)) ||
                       (r_item.msg_operation == 16'(arpc_pkg::OP_REPLY))) &&
                      (r_item.msg_hw_type    == r_exp_hw_type) &&
                      (r_item.msg_proto_type == r_exp_proto_type) &&
                      (r_item.msg_hw_len     == r_exp_hw_len) &&
                      (r_item.msg_proto_len  == r_exp_proto_len) &&
                      (r_item.sender_mac != 48'd0) &&
                      (r_item.sender_ip  != 32'd0) &&
                      (r_item.target_ip  != 32'd0);
    assign w_known  = ((r_item.sender_ip == r_own_ip) && (r_own_mac != 48'd0)) || r_hit;
    assign w_full   = (r_fill == FILL_W'(ENTRIES));
    assign w_learn  = w_is_msg && w_msg_ok && !w_known && !w_full;
    assign w_drop   = w_is_msg && w_msg_ok && !w_known && w_full;
    // Reply does not depend on the checks
    assign w_reply  = w_is_msg && (r_item.target_ip == r_own_ip) &&
                      (r_item.target_mac == 48'd0);

    always_comb begin
        w_res = '0;
        case (r_item.kind)
            arpc_pkg::KIND_MSG: begin
                w_res.message_valid = w_msg_ok;
                w_res.learned       = w_learn;
                w_res.table_full    = w_drop;
                if (w_reply) begin
                    w_res.emit           = 1'b1;
                    w_res.out_operation  = arpc_pkg::OP_REPLY;
                    w_res.out_sender_mac = r_own_mac;
                    w_res.out_sender_ip  = r_own_ip;
                    w_res.out_target_mac = r_item.sender_mac;
                    w_res.out_target_ip  = r_item.sender_ip;
                end
            end
            arpc_pkg::KIND_LOOKUP: begin
                w_res.lookup_hit = r_hit;
                w_res.lookup_mac = r_hit ? r_mac : 48'd0;
            end
            arpc_pkg::KIND_REQUEST: begin
                w_res.emit           = 1'b1;
                w_res.out_operation  = arpc_pkg::OP_REQUEST;
                w_res.out_sender_mac = r_own_mac;
                w_res.out_sender_ip  = r_own_ip;
                w_res.out_target_ip  = r_item.target_ip;
            end
            default: begin
            end
        endcase
    end

    // Store a new neighbor in the next free cell
    always_comb begin
        w_wr.en  = w_finish && w_learn;
        w_wr.ip  = r_item.sender_ip;
        w_wr.mac = r_item.sender_mac;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_wr.en) begin
            r_fill <= r_fill + FILL_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_finish) r_out <= w_res;
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // The token leaves the row only while a search is running
    a_tail_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[ENTRIES].vld |-> (r_state == arpc_pkg::S_SEARCH))
        else $error("search token left the row outside a search");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(ENTRIES))
        else $error("fill count beyond table depth");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |=> (r_fill == $past(r_fill) + FILL_W'(1)))
        else $error("fill count did not advance on a learn");

    a_learn_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.learned) |->
        (o_rsp.data.message_valid && !o_rsp.data.table_full))
        else $error("learn reported without a valid message");

endmodule

`default_nettype wire
